// File: src/sgot_pkg.sv
// Shared types and codes for the spatial grid object table.
`timescale 1ns / 1ps
package sgot_pkg;

    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned IDENT_W  = 16;
    localparam int unsigned ENTRY_W  = IDENT_W + TYPE_W;

    typedef enum logic [1:0] {
        ACT_TEST   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_DEL_TY = 2'd2,
        ACT_DEL_ID = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_COL_CX   = 3'd2,
        REG_COL_CY   = 3'd3,
        REG_ROW_CX   = 3'd4,
        REG_ROW_CY   = 3'd5
    } t_reg_index;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,   // zero the fill counts after reset
        S_IDLE,
        S_MUL,     // one product per cycle, four products
        S_RANGE,   // abs, floor, range check
        S_FILL,    // fill count of the addressed cell is on the read port
        S_SCAN,    // issue slot reads
        S_CHECK,   // compare read entry
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

endpackage

// File: src/sgot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module sgot_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/sgot_mac.sv
// Shared 16x17 signed multiply-accumulate unit for the cell projection.
`timescale 1ns / 1ps
module sgot_mac (
    input  logic               i_clk,
    input  logic               i_clear,
    input  logic               i_en,
    input  logic signed [15:0] i_a,
    input  logic signed [16:0] i_b,
    output logic signed [34:0] o_acc
);
    logic signed [34:0] r_acc;
    logic signed [34:0] n_acc;
    logic signed [32:0] w_prod;

    // One product per cycle into the accumulator while i_en is high and i_clear is low.
    always_comb begin
        w_prod = i_a * i_b;
        n_acc  = r_acc;
        if (i_clear) begin
            n_acc = 35'sd0;
        end else if (i_en) begin
            n_acc = r_acc + 35'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule

// File: src/spatial_grid_object_table.sv
// Top level: configuration, sequencer, cell fill counts and slot memory.
//
//  channel | signals                                   | direction
//  input   | i_valid/o_ready, action, point, type, id  | in
//  result  | o_valid/i_ready, hit, found_ident, status | out
//  config  | i_cfg_valid/o_cfg_ready, index, data      | in
//
// One item at a time. Projection: four products through the shared multiplier,
// then abs, floor and range check per axis, then a read of the cell fill count.
// Test and type delete then scan the slots of the cell, reading and comparing
// each, and a delete shifts the later slots of the cell down by one.
// Delete by id reads every fill count and every filled slot in the worst case.
// Reset is synchronous; a pass over all GRID_COLS*GRID_ROWS cells then clears the
// fill counts with o_ready low; slot contents are never cleared. A finished item
// holds in its last state while the previous result is still not taken.
`timescale 1ns / 1ps
module spatial_grid_object_table #(
    parameter int GRID_COLS  = 16,
    parameter int GRID_ROWS  = 16,
    parameter int CELL_SLOTS = 4,
    parameter int COEFF_FRAC = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_point_x,
    input  logic [15:0] i_point_y,
    input  logic [7:0]  i_type_bits,
    input  logic [15:0] i_object_ident,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [15:0] o_found_ident,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SLOT_W    = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
    localparam int FILL_W    = $clog2(CELL_SLOTS + 1);
    localparam int DEPTH     = NUM_CELLS * CELL_SLOTS;
    localparam int ADDR_W    = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
    localparam int SHIFT     = COEFF_FRAC + 4;
    localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    // Configuration registers.
    logic signed [15:0] r_cfg [sgot_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sgot_pkg::NUM_REGS; i++) begin
                r_cfg[i] <= 16'sd0;
            end
        end else if (i_cfg_valid && int'(i_cfg_index) < sgot_pkg::NUM_REGS) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Control registers.
    sgot_pkg::t_state  r_state, n_state;
    sgot_pkg::t_action r_act;
    logic [7:0]        r_type;
    logic [15:0]       r_ident;
    logic signed [16:0] r_dx, r_dy;
    logic [1:0]        r_mstep;
    logic [CELL_W-1:0] r_cell;
    logic [SLOT_W:0]   r_k;
    logic [FILL_W-1:0] r_n;
    logic              r_hit;
    logic [15:0]       r_found;
    logic [1:0]        r_status;
    logic              r_ovalid;
    logic [CELL_W-1:0] r_col_part;
    logic              r_col_bad;

    // Shared multiplier.
    logic               w_mac_clear, w_mac_en;
    logic signed [15:0] w_mac_a;
    logic signed [16:0] w_mac_b;
    logic signed [34:0] w_acc;

    sgot_mac u_mac (
        .i_clk  (i_clk),
        .i_clear(w_mac_clear),
        .i_en   (w_mac_en),
        .i_a    (w_mac_a),
        .i_b    (w_mac_b),
        .o_acc  (w_acc)
    );

    always_comb begin
        w_mac_a = r_cfg[{1'b0, r_mstep} + 3'd2];
        w_mac_b = r_mstep[0] ? r_dy : r_dx;
        w_mac_en = (r_state == sgot_pkg::S_MUL);
        w_mac_clear = (r_state == sgot_pkg::S_RANGE) || (r_state == sgot_pkg::S_IDLE);
    end

    // Absolute value and floor of the accumulator.
    logic [34:0] w_abs;
    logic [34:0] w_idx;
    always_comb begin
        w_abs = w_acc[34] ? 35'(-w_acc) : 35'(w_acc);
        w_idx = w_abs >> SHIFT;
    end

    // Cell index and range check once the row is known.
    logic [CELL_W-1:0] w_cell_idx;
    logic              w_outside;
    assign w_cell_idx = CELL_W'(ROW_W'(w_idx)) * CELL_W'(GRID_COLS) + r_col_part;
    assign w_outside  = r_col_bad || (w_idx >= 35'(GRID_ROWS));

    // Slot memory.
    logic                      w_we;
    logic [ADDR_W-1:0]         w_waddr, w_raddr;
    logic [sgot_pkg::ENTRY_W-1:0] w_wdata, w_rdata;

    sgot_ram #(.WIDTH(sgot_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Fill count memory.
    logic              w_fwe;
    logic [CELL_W-1:0] w_fwaddr, w_fraddr;
    logic [FILL_W-1:0] w_fwdata, w_fill;
    logic              w_full;

    sgot_ram #(.WIDTH(FILL_W), .DEPTH(NUM_CELLS)) u_fill (
        .i_clk  (i_clk),
        .i_we   (w_fwe),
        .i_waddr(w_fwaddr),
        .i_wdata(w_fwdata),
        .i_raddr(w_fraddr),
        .o_rdata(w_fill)
    );

    assign w_full = (w_fill >= FILL_W'(CELL_SLOTS));

    logic [ADDR_W-1:0] w_base;
    assign w_base = ADDR_W'(32'(r_cell) * CELL_SLOTS);
    assign w_raddr = w_base + ADDR_W'(r_k);

    logic w_match;
    always_comb begin
        unique case (r_act)
            sgot_pkg::ACT_TEST:   w_match = |(w_rdata[7:0] & r_type);
            sgot_pkg::ACT_DEL_TY: w_match = (w_rdata[7:0] == r_type);
            default: w_match = (w_rdata[7:0] == r_type) && (w_rdata[23:8] == r_ident);
        endcase
    end

    logic w_last_cell;
    assign w_last_cell = (32'(r_cell) == NUM_CELLS - 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgot_pkg::S_CLEAR:
                if (w_last_cell) n_state = sgot_pkg::S_IDLE;
            sgot_pkg::S_IDLE:
                if (i_valid) begin
                    n_state = (sgot_pkg::t_action'(i_action) == sgot_pkg::ACT_DEL_ID)
                              ? sgot_pkg::S_FILL : sgot_pkg::S_MUL;
                end
            sgot_pkg::S_MUL:
                if (r_mstep[0]) n_state = sgot_pkg::S_RANGE;
            sgot_pkg::S_RANGE:
                if (r_mstep == 2'd0) begin
                    if (w_outside) begin
                        n_state = sgot_pkg::S_DONE;
                    end else begin
                        n_state = sgot_pkg::S_FILL;
                    end
                end else begin
                    n_state = sgot_pkg::S_MUL;
                end
            sgot_pkg::S_FILL:
                if (r_act == sgot_pkg::ACT_ADD) n_state = sgot_pkg::S_DONE;
                else n_state = sgot_pkg::S_SCAN;
            sgot_pkg::S_SCAN:
                if ({1'b0, r_k} >= (SLOT_W + 2)'(r_n)) begin
                    if (r_act == sgot_pkg::ACT_DEL_ID && !w_last_cell) begin
                        n_state = sgot_pkg::S_FILL;
                    end else begin
                        n_state = sgot_pkg::S_DONE;
                    end
                end else begin
                    n_state = sgot_pkg::S_CHECK;
                end
            sgot_pkg::S_CHECK:
                if (w_match) begin
                    n_state = (r_act == sgot_pkg::ACT_TEST) ? sgot_pkg::S_DONE
                                                            : sgot_pkg::S_SHIFT_RD;
                end else begin
                    n_state = sgot_pkg::S_SCAN;
                end
            sgot_pkg::S_SHIFT_RD:
                if ({1'b0, r_k} >= (SLOT_W + 2)'(r_n)) n_state = sgot_pkg::S_DONE;
                else n_state = sgot_pkg::S_SHIFT_WR;
            sgot_pkg::S_SHIFT_WR:
                n_state = sgot_pkg::S_SHIFT_RD;
            sgot_pkg::S_DONE:
                if (!r_ovalid || i_ready) n_state = sgot_pkg::S_IDLE;
            default: n_state = sgot_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: slot and fill memory ports.
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = w_base + ADDR_W'(r_k);
        w_wdata  = {r_ident, r_type};
        w_fwe    = 1'b0;
        w_fwaddr = r_cell;
        w_fwdata = '0;
        w_fraddr = r_cell;
        unique case (r_state)
            sgot_pkg::S_CLEAR: begin
                w_fwe = 1'b1;
            end
            sgot_pkg::S_IDLE: begin
                w_fraddr = '0;
            end
            sgot_pkg::S_RANGE: begin
                w_fraddr = w_cell_idx;
            end
            sgot_pkg::S_FILL: begin
                w_we     = (r_act == sgot_pkg::ACT_ADD) && !w_full;
                w_waddr  = w_base + ADDR_W'(w_fill);
                w_fwe    = (r_act == sgot_pkg::ACT_ADD) && !w_full;
                w_fwdata = w_fill + FILL_W'(1);
            end
            sgot_pkg::S_SCAN: begin
                w_fraddr = r_cell + CELL_W'(1);
            end
            sgot_pkg::S_CHECK: begin
                w_fwe    = w_match && (r_act != sgot_pkg::ACT_TEST);
                w_fwdata = r_n - FILL_W'(1);
            end
            sgot_pkg::S_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = w_base + ADDR_W'(r_k) - ADDR_W'(1);
                w_wdata = w_rdata;
            end
            default: ;
        endcase
    end

    // Datapath and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sgot_pkg::S_CLEAR;
            r_ovalid <= 1'b0;
            r_cell   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == sgot_pkg::S_DONE && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                sgot_pkg::S_CLEAR:
                    r_cell <= r_cell + CELL_W'(1);
                sgot_pkg::S_IDLE:
                    if (i_valid) begin
                        r_act    <= sgot_pkg::t_action'(i_action);
                        r_type   <= i_type_bits;
                        r_ident  <= i_object_ident;
                        r_dx     <= 17'(signed'(i_point_x)) - 17'(r_cfg[0]);
                        r_dy     <= 17'(signed'(i_point_y)) - 17'(r_cfg[1]);
                        r_mstep  <= 2'd0;
                        r_cell   <= '0;
                        r_k      <= '0;
                        r_hit    <= 1'b0;
                        r_found  <= 16'd0;
                        r_status <= (sgot_pkg::t_action'(i_action) == sgot_pkg::ACT_TEST
                                     || sgot_pkg::t_action'(i_action) == sgot_pkg::ACT_ADD)
                                    ? sgot_pkg::ST_OK : sgot_pkg::ST_MISSING;
                    end
                sgot_pkg::S_MUL:
                    r_mstep <= r_mstep + 2'd1;
                sgot_pkg::S_RANGE:
                    if (r_mstep == 2'd2) begin
                        r_col_bad  <= (w_idx >= 35'(GRID_COLS));
                        r_col_part <= CELL_W'(COL_W'(w_idx));
                        r_mstep    <= 2'd2;
                    end else begin
                        if (w_outside) begin
                            r_status <= sgot_pkg::ST_OUTSIDE;
                            r_hit    <= 1'b0;
                        end else begin
                            r_cell <= w_cell_idx;
                        end
                    end
                sgot_pkg::S_FILL: begin
                    r_n <= w_fill;
                    if (r_act == sgot_pkg::ACT_ADD && w_full) r_status <= sgot_pkg::ST_FULL;
                end
                sgot_pkg::S_SCAN:
                    if ({1'b0, r_k} >= (SLOT_W + 2)'(r_n)
                        && r_act == sgot_pkg::ACT_DEL_ID && !w_last_cell) begin
                        r_cell <= r_cell + CELL_W'(1);
                        r_k    <= '0;
                    end
                sgot_pkg::S_CHECK:
                    if (w_match) begin
                        if (r_act == sgot_pkg::ACT_TEST) begin
                            r_hit <= 1'b1;
                        end else begin
                            r_status <= sgot_pkg::ST_OK;
                            if (r_act == sgot_pkg::ACT_DEL_TY) r_found <= w_rdata[23:8];
                            r_k <= r_k + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                sgot_pkg::S_SHIFT_WR:
                    r_k <= r_k + 1'b1;
                default: ;
            endcase
        end
    end

    // Result register.
    logic        r_o_hit;
    logic [15:0] r_o_found;
    logic [1:0]  r_o_status;
    always_ff @(posedge i_clk) begin
        if (r_state == sgot_pkg::S_DONE && (!r_ovalid || i_ready)) begin
            r_o_hit    <= r_hit;
            r_o_found  <= r_found;
            r_o_status <= r_status;
        end
    end

    assign o_ready       = (r_state == sgot_pkg::S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_hit         = r_o_hit;
    assign o_found_ident = r_o_found;
    assign o_status      = r_o_status;
endmodule
